FILE: sv/ntcth_pkg.sv
// ----------------------------------------------------------------------------
// ntcth_pkg
// Shared types, constants and the beta-equation table builder for the NTC
// thermistor thermometer.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcth_pkg;

  // Batch and converter geometry
  localparam int SAMPLE_COUNT = 16;
  localparam int ADC_BITS     = 12;

  // Fixed port field widths
  localparam int SAMPLE_W   = 12;
  localparam int MEAN_OUT_W = 16;
  localparam int TEMP_W     = 19;
  localparam int WEIGHT_W   = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(9830);

  localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
  localparam int TRIM_EACH  = SAMPLE_COUNT / 4;
  localparam int KEEP_COUNT = SAMPLE_COUNT - 2 * TRIM_EACH;

  localparam int ROW_W     = $clog2(SAMPLE_COUNT);
  localparam int SUM_W     = ADC_BITS + $clog2(KEEP_COUNT + 1);
  localparam int DIV_W     = SUM_W + 4;
  localparam int MEAN_W    = ADC_BITS + 4;
  localparam int STEP_W    = $clog2(KEEP_COUNT);
  localparam int ROM_DEPTH = 1 << ADC_BITS;

  // Reciprocal of KEEP_COUNT, rounded up, for an exact floor division
  localparam int RECIP_SH = DIV_W + $clog2(KEEP_COUNT);
  localparam int RECIP_W  = DIV_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SH) + 64'(KEEP_COUNT) - 64'd1) / 64'(KEEP_COUNT);

  // Temperature limits in 1/256 degree C
  localparam int TEMP_MIN = -69888;
  localparam int TEMP_MAX = 256000;

  // Beta equation constants
  localparam longint BETA_K        = 3950;
  localparam longint T0_HUNDREDTHS = 29815;
  localparam longint ZERO_C_2560   = 699264;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_ROM,
    ST_MUL,
    ST_EMA
  } ntcth_state_t;

  typedef struct packed {
    logic              insert;
    logic [ROW_W-1:0]  fill;
    logic              acc_clr;
    logic              acc_en;
    logic              div_load;
    logic              div_step;
    logic [STEP_W-1:0] step;
    logic              rom_rd;
    logic              mul_en;
    logic              result_load;
  } ntcth_cmd_t;

  function automatic longint unsigned log2_q24(longint unsigned x);
    int unsigned       n;
    longint unsigned   m;
    longint unsigned   r;
    n = 0;
    for (int k = 1; k < 32; k++) begin
      if ((x >> k) != 64'd0) n = k;
    end
    m = x << (30 - n);
    r = 64'(n) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << i);
      end
    end
    return r;
  endfunction

  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((num >> i) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic logic signed [TEMP_W-1:0] table_temp(int unsigned a);
    int unsigned     b;
    longint          d;
    longint unsigned mag;
    longint          lnq;
    longint          den;
    longint          num;
    longint          p;
    longint          dd;
    longint          h;
    longint          t;
    b   = FULL_SCALE - a;
    d   = longint'(log2_q24(64'(a))) - longint'(log2_q24(64'(b)));
    mag = (d < 0) ? longint'(-d) : longint'(d);
    lnq = longint'((mag * LN2_Q30 + (64'd1 << 29)) >> 30);
    if (d < 0) lnq = -lnq;
    den = longint'(100) * BETA_K * (longint'(1) << 24) + T0_HUNDREDTHS * lnq;
    if (den <= 0) return TEMP_W'(TEMP_MAX);
    num = longint'(256) * BETA_K * T0_HUNDREDTHS * (longint'(1) << 24);
    p   = num * 10 - ZERO_C_2560 * den;
    dd  = den * 10;
    h   = dd >>> 1;
    if (p >= 0) t = longint'(udiv64(64'(p + h), 64'(dd)));
    else        t = -longint'(udiv64(64'(-p + h), 64'(dd)));
    if (t < TEMP_MIN) t = TEMP_MIN;
    if (t > TEMP_MAX) t = TEMP_MAX;
    return TEMP_W'(t);
  endfunction

endpackage

`default_nettype wire

FILE: sv/ntcth_sort_row.sv
// ----------------------------------------------------------------------------
// ntcth_sort_row
// Row of sample cells kept in ascending order by insertion as samples arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcth_sort_row
  import ntcth_pkg::*;
(
  input  logic                clk,
  input  logic                insert,
  input  logic [ROW_W-1:0]    fill,
  input  logic [ADC_BITS-1:0] sample,
  input  logic [ROW_W-1:0]    rd_idx,
  output logic [ADC_BITS-1:0] rd_data
);

  logic [ADC_BITS-1:0] cells      [SAMPLE_COUNT];
  logic [ADC_BITS-1:0] cells_next [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0] le;

  always_comb begin
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      le[i] = (ROW_W'(i) < fill) && (cells[i] <= sample);
    end
    cells_next[0] = le[0] ? cells[0] : sample;
    for (int i = 1; i < SAMPLE_COUNT; i++) begin
      if (le[i]) begin
        cells_next[i] = cells[i];
      end else if (le[i-1]) begin
        cells_next[i] = sample;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  assign rd_data = cells[rd_idx];

endmodule

`default_nettype wire

FILE: sv/ntcth_datapath.sv
// ----------------------------------------------------------------------------
// ntcth_datapath
// Trimmed sum, reciprocal mean scaling, temperature ROM, EMA update and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcth_datapath
  import ntcth_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ntcth_cmd_t               cmd,
  input  logic [SAMPLE_W-1:0]      adc_sample,
  input  logic                     cfg_wr_en,
  input  logic [WEIGHT_W-1:0]      cfg_wr_data,
  output logic [MEAN_OUT_W-1:0]    trimmed_mean,
  output logic                     mean_invalid,
  output logic signed [TEMP_W-1:0] batch_temperature,
  output logic signed [TEMP_W-1:0] filtered_temperature
);

  localparam int PROD_W  = WEIGHT_W + 1 + TEMP_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SCALE_W = DIV_W + RECIP_W;
  localparam logic [MEAN_W-1:0] MEAN_FULL = MEAN_W'(FULL_SCALE << 4);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(TEMP_MIN);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(TEMP_MAX);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(32768);

  logic [ADC_BITS-1:0] row_data;
  logic [ROW_W-1:0]    row_sel;

  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_sum;

  logic [DIV_W-1:0]   dividend;
  logic [SCALE_W-1:0] scaled;

  logic [MEAN_W-1:0]   mean;
  logic                mean_bad;
  logic [ADC_BITS-1:0] rom_idx;

  logic signed [TEMP_W-1:0] temp_rom [ROM_DEPTH];
  logic signed [TEMP_W-1:0] rom_q;

  logic [WEIGHT_W-1:0]      ema_weight;
  logic signed [TEMP_W-1:0] ema;
  logic signed [TEMP_W:0]   temp_diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  ema_acc;
  logic signed [ACC_W-1:0]  ema_sh;
  logic signed [TEMP_W-1:0] ema_upd;

  assign row_sel = ROW_W'(32'(TRIM_EACH) + 32'(cmd.step));

  ntcth_sort_row u_sort_row (
    .clk     (clk),
    .insert  (cmd.insert),
    .fill    (cmd.fill),
    .sample  (ADC_BITS'(adc_sample)),
    .rd_idx  (row_sel),
    .rd_data (row_data)
  );

  assign acc_sum = acc + SUM_W'(row_data);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dividend <= {acc_sum, 4'b0000};
    end
  end

  assign scaled = SCALE_W'(dividend) * SCALE_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      mean <= scaled[RECIP_SH +: MEAN_W];
    end
  end

  assign mean_bad = (mean == '0) || (mean >= MEAN_FULL);
  assign rom_idx  = (mean[MEAN_W-1:4] == '0) ? ADC_BITS'(1) : mean[MEAN_W-1:4];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic signed [TEMP_W-1:0] Entry = table_temp(g);
    assign temp_rom[g] = Entry;
  end

  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      rom_q <= temp_rom[rom_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_weight <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      ema_weight <= cfg_wr_data;
    end
  end

  assign temp_diff = {rom_q[TEMP_W-1], rom_q} - {ema[TEMP_W-1], ema};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= $signed({1'b0, ema_weight}) * temp_diff;
    end
  end

  always_comb begin
    ema_acc = ACC_W'(prod) + (ACC_W'(ema) <<< 16) + ACC_HALF;
    ema_sh  = ema_acc >>> 16;
    if (ema_sh < ACC_MIN) begin
      ema_upd = TEMP_W'(TEMP_MIN);
    end else if (ema_sh > ACC_MAX) begin
      ema_upd = TEMP_W'(TEMP_MAX);
    end else begin
      ema_upd = ema_sh[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema <= '0;
    end else if (cmd.result_load && !mean_bad) begin
      ema <= ema_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      trimmed_mean         <= MEAN_OUT_W'(mean);
      mean_invalid         <= mean_bad;
      batch_temperature    <= mean_bad ? '0 : rom_q;
      filtered_temperature <= mean_bad ? ema : ema_upd;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ntcth_ctrl.sv
// ----------------------------------------------------------------------------
// ntcth_ctrl
// Sequencer: batch fill, trimmed sum, mean division, lookup, EMA and result
// handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcth_ctrl
  import ntcth_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ntcth_cmd_t cmd
);

  ntcth_state_t      state;
  ntcth_state_t      state_next;
  logic [ROW_W-1:0]  fill;
  logic [ROW_W-1:0]  fill_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    step_next  = step;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.fill   = fill;
    cmd.step   = step;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.insert = 1'b1;
          if (fill == ROW_W'(SAMPLE_COUNT - 1)) begin
            fill_next   = '0;
            step_next   = '0;
            cmd.acc_clr = 1'b1;
            state_next  = ST_SUM;
          end else begin
            fill_next = fill + 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd.acc_en = 1'b1;
        if (step == STEP_W'(KEEP_COUNT - 1)) begin
          cmd.div_load = 1'b1;
          step_next    = '0;
          state_next   = ST_DIV;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = ST_ROM;
      end
      ST_ROM: begin
        cmd.rom_rd = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_EMA;
      end
      ST_EMA: begin
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    priority if (cmd.result_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ntc_trimmed_mean_ema_thermometer.sv
// ----------------------------------------------------------------------------
// ntc_trimmed_mean_ema_thermometer
// NTC thermistor thermometer: trimmed-mean batch filter, beta-equation
// lookup and exponential moving average.
// ----------------------------------------------------------------------------
// Each 12-bit ADC sample is inserted in order into a 16-entry sorted row.
// The sample that completes a batch starts processing: the middle half of
// the row is summed one entry per cycle, the sum is scaled into a Q12.4
// mean by a reciprocal multiply, then the temperature ROM read, the EMA
// multiply and the EMA update follow in that order. No samples are taken
// during processing. The result sits in an output register, so the next
// batch fills while it waits; only the EMA update stalls until the previous
// result is transferred. A mean of 0 or full scale flags mean_invalid,
// reports batch_temperature 0 and leaves the EMA unchanged. The EMA weight
// (Q0.16, reset 0.15) is written through cfg_wr_en and cfg_wr_data; write it
// only while the block is idle, which the block itself does not enforce.
// Rows are not cleared after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_trimmed_mean_ema_thermometer
  import ntcth_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      adc_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MEAN_OUT_W-1:0]    trimmed_mean,
  output logic                     mean_invalid,
  output logic signed [TEMP_W-1:0] batch_temperature,
  output logic signed [TEMP_W-1:0] filtered_temperature,
  input  logic                     cfg_wr_en,
  input  logic [WEIGHT_W-1:0]      cfg_wr_data
);

  ntcth_cmd_t cmd;

  ntcth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ntcth_datapath u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .adc_sample           (adc_sample),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .trimmed_mean         (trimmed_mean),
    .mean_invalid         (mean_invalid),
    .batch_temperature    (batch_temperature),
    .filtered_temperature (filtered_temperature)
  );

endmodule

`default_nettype wire

FILE: sv/ntcth_checker.sv
// ----------------------------------------------------------------------------
// ntcth_checker
// Port-level checks of the thermometer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcth_checker
  import ntcth_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [SAMPLE_W-1:0]      adc_sample,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [MEAN_OUT_W-1:0]    trimmed_mean,
  input logic                     mean_invalid,
  input logic signed [TEMP_W-1:0] batch_temperature,
  input logic signed [TEMP_W-1:0] filtered_temperature,
  input logic                     cfg_wr_en,
  input logic [WEIGHT_W-1:0]      cfg_wr_data
);

  logic unused_inputs;
  assign unused_inputs = in_valid ^ in_ready ^ (^adc_sample) ^ cfg_wr_en ^ (^cfg_wr_data);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trimmed_mean)
      && $stable(filtered_temperature))
    else $error("result changed before transfer");

  a_invalid_zero_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && mean_invalid |-> batch_temperature == '0)
    else $error("invalid mean with nonzero batch temperature");

  a_valid_mean_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mean_invalid |-> trimmed_mean != '0)
    else $error("zero mean not flagged invalid");

  a_filtered_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> filtered_temperature >= TEMP_MIN && filtered_temperature <= TEMP_MAX)
    else $error("filtered temperature out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ntc_trimmed_mean_ema_thermometer ntcth_checker u_checker (.*);

`default_nettype wire
